@@ hdl/blr_pkg.sv @@
// shared types, widths and codes for the line rasterizer
// no dependencies; used by every module under hdl

package blr_pkg;

  localparam int COORD_BITS = 15;
  localparam int DIM_BITS   = 14;
  localparam int COLOR_BITS = 16;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(320);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(240);

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_USER_W     = 2;
  localparam int CMP_W          = (COORD_BITS - 1 > DIM_BITS) ? COORD_BITS - 1 : DIM_BITS;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic        [COORD_BITS-1:0] delta_t;
  typedef logic signed [COORD_BITS:0]   err_t;
  typedef logic        [COLOR_BITS-1:0] color_t;
  typedef logic        [DIM_BITS-1:0]   dim_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  // normalized command handed from front to back
  typedef struct packed {
    op_t    op;
    logic   steep;
    logic   minor_neg;
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    delta_t d_major;
    delta_t d_minor;
    color_t color;
  } cmd_t;

endpackage

@@ hdl/blr_front.sv @@
// front end: accepts input items, registers endpoint differences, then normalizes
// a start into major/minor form; depends on blr_pkg

module blr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  blr_pkg::op_t                  in_op,
  input  logic [blr_pkg::IN_DATA_W-1:0] in_data,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output blr_pkg::cmd_t                 cmd
);

  localparam int CB = blr_pkg::COORD_BITS;

  logic            f1_valid_r;
  blr_pkg::op_t    op_r;
  blr_pkg::coord_t ax_r, ay_r, bx_r, by_r;
  blr_pkg::diff_t  dx_r, dy_r;
  blr_pkg::color_t color_r;

  blr_pkg::coord_t ax_in, ay_in, bx_in, by_in;
  blr_pkg::diff_t  adx, ady, md, mr;
  logic            steep, swap;
  blr_pkg::coord_t maj_a, maj_b, min_a, min_b;

  assign ax_in = in_data[CB-1:0];
  assign ay_in = in_data[2*CB-1:CB];
  assign bx_in = in_data[3*CB-1:2*CB];
  assign by_in = in_data[4*CB-1:3*CB];

  assign in_ready  = !f1_valid_r || cmd_ready;
  assign cmd_valid = f1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (in_ready) begin
      f1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r    <= in_op;
      ax_r    <= ax_in;
      ay_r    <= ay_in;
      bx_r    <= bx_in;
      by_r    <= by_in;
      dx_r    <= blr_pkg::diff_t'(bx_in) - blr_pkg::diff_t'(ax_in);
      dy_r    <= blr_pkg::diff_t'(by_in) - blr_pkg::diff_t'(ay_in);
      color_r <= in_data[4*CB+blr_pkg::COLOR_BITS-1:4*CB];
    end
  end

  always_comb begin
    adx   = dx_r[CB] ? -dx_r : dx_r;
    ady   = dy_r[CB] ? -dy_r : dy_r;
    steep = ady > adx;
    md    = steep ? dy_r : dx_r;
    mr    = steep ? dx_r : dy_r;
    maj_a = steep ? ay_r : ax_r;
    maj_b = steep ? by_r : bx_r;
    min_a = steep ? ax_r : ay_r;
    min_b = steep ? bx_r : by_r;
    // endpoints reversed when the major coordinate falls
    swap  = md[CB];

    cmd.op        = op_r;
    cmd.steep     = steep;
    cmd.major_pos = swap ? maj_b : maj_a;
    cmd.major_end = swap ? maj_a : maj_b;
    cmd.minor_pos = swap ? min_b : min_a;
    // minor steps down unless the ordered minor difference is positive
    cmd.minor_neg = swap ? !mr[CB] : (mr[CB] || (mr == '0));
    cmd.d_major   = steep ? ady[CB-1:0] : adx[CB-1:0];
    cmd.d_minor   = steep ? adx[CB-1:0] : ady[CB-1:0];
    cmd.color     = color_r;
  end

endmodule

@@ hdl/blr_queue.sv @@
// short command queue between front and back ends
// depends on blr_pkg

module blr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  blr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output blr_pkg::cmd_t pop_cmd
);

  localparam int AW = blr_pkg::Q_AW;

  blr_pkg::cmd_t  entry_r [blr_pkg::Q_DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != (AW+1)'(blr_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hdl/blr_back.sv @@
// back end: holds the line state, steps the error term and drives the result register
// depends on blr_pkg

module blr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  blr_pkg::cmd_t                  cmd,
  input  blr_pkg::dim_t                  screen_width,
  input  blr_pkg::dim_t                  screen_height,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [blr_pkg::OUT_DATA_W-1:0] out_data,
  output logic [blr_pkg::OUT_USER_W-1:0] out_user,
  output logic                           out_last
);

  localparam int CB = blr_pkg::COORD_BITS;
  localparam int CW = blr_pkg::CMP_W;

  logic            busy_r;
  logic            steep_r, minor_neg_r;
  blr_pkg::coord_t major_pos_r, major_end_r, minor_pos_r;
  blr_pkg::delta_t d_major_r, d_minor_r;
  blr_pkg::err_t   err_r;
  blr_pkg::color_t color_r;

  logic                           out_valid_r;
  logic [blr_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [blr_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                           out_last_r, out_last_nxt;

  logic            take, do_pixel;
  blr_pkg::coord_t px, py;
  logic            last, on_x, on_y;
  blr_pkg::err_t   err_sub;

  assign cmd_ready = !out_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign do_pixel  = take && (cmd.op == blr_pkg::OP_STEP) && busy_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;
  assign out_last  = out_last_r;

  always_comb begin
    px      = steep_r ? minor_pos_r : major_pos_r;
    py      = steep_r ? major_pos_r : minor_pos_r;
    last    = major_pos_r >= major_end_r;
    on_x    = !px[CB-1] && (CW'(px[CB-2:0]) < CW'(screen_width));
    on_y    = !py[CB-1] && (CW'(py[CB-2:0]) < CW'(screen_height));
    err_sub = err_r - blr_pkg::err_t'({1'b0, d_minor_r});

    out_data_nxt = '0;
    out_user_nxt = '0;
    out_last_nxt = 1'b0;
    if (do_pixel) begin
      out_data_nxt[CB-1:0]    = px;
      out_data_nxt[2*CB-1:CB] = py;
      out_data_nxt[2*CB+blr_pkg::COLOR_BITS-1:2*CB] = color_r;
      out_user_nxt = {on_x && on_y, 1'b1};
      out_last_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      if (cmd_ready) begin
        out_valid_r <= cmd_valid;
      end
      if (take) begin
        if (cmd.op == blr_pkg::OP_START) begin
          busy_r <= 1'b1;
        end else if (do_pixel && last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steep_r     <= 1'b0;
      minor_neg_r <= 1'b0;
      major_pos_r <= '0;
      major_end_r <= '0;
      minor_pos_r <= '0;
      d_major_r   <= '0;
      d_minor_r   <= '0;
      err_r       <= '0;
      color_r     <= '0;
    end else if (take && (cmd.op == blr_pkg::OP_START)) begin
      steep_r     <= cmd.steep;
      minor_neg_r <= cmd.minor_neg;
      major_pos_r <= cmd.major_pos;
      major_end_r <= cmd.major_end;
      minor_pos_r <= cmd.minor_pos;
      d_major_r   <= cmd.d_major;
      d_minor_r   <= cmd.d_minor;
      err_r       <= blr_pkg::err_t'({1'b0, cmd.d_major >> 1});
      color_r     <= cmd.color;
    end else if (do_pixel) begin
      if (err_sub[CB]) begin
        minor_pos_r <= minor_neg_r ? minor_pos_r - 1'b1 : minor_pos_r + 1'b1;
        err_r       <= err_sub + blr_pkg::err_t'({1'b0, d_major_r});
      end else begin
        err_r <= err_sub;
      end
      if (!last) begin
        major_pos_r <= major_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
      out_last_r <= out_last_nxt;
    end
  end

endmodule

@@ hdl/bresenham_line_raster.sv @@
// top level of the bresenham line rasterizer: config registers, front, queue, back
// depends on blr_pkg, blr_front, blr_queue, blr_back
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready | tuser op; tdata endpoints and color
//  out_    | master    | out_tvalid/tready   | tuser valid, on-screen; tdata x,y,color; tlast
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// one item per clock sustained while the output is not stalled; a result passes through
// the front difference register, the command queue and the output register in turn
// the start normalization is split over the front register and the queue input,
// the step update is one subtract, compare and add in the back end
// rst_n is synchronous and clears all control state; sizes come back as 320 by 240
// a stalled output holds the back end; the four-entry queue keeps the front accepting until full

module bresenham_line_raster (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [blr_pkg::IN_DATA_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y, line_color, pad
  input  logic                           in_tuser,   // op
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [blr_pkg::OUT_DATA_W-1:0] out_tdata,  // pixel_x, pixel_y, pixel_color, pad
  output logic [blr_pkg::OUT_USER_W-1:0] out_tuser,  // pixel_valid, on_screen
  output logic                           out_tlast,  // last_pixel
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [blr_pkg::DIM_BITS-1:0]   cfg_data
);

  blr_pkg::dim_t screen_width_r, screen_height_r;

  logic          f_valid, f_ready;
  blr_pkg::cmd_t f_cmd;
  logic          q_valid, q_ready;
  blr_pkg::cmd_t q_cmd;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= blr_pkg::WIDTH_RESET;
      screen_height_r <= blr_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (blr_pkg::cfg_idx_t'(cfg_index))
        blr_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        blr_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: takes items, normalizes starts
  blr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (blr_pkg::op_t'(in_tuser)),
    .in_data   (in_tdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // decoupling queue
  blr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // back: line stepping and result register
  blr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_tdata),
    .out_user      (out_tuser),
    .out_last      (out_tlast)
  );

endmodule

@@ dv/blr_line_checker.sv @@
// scoreboard for the bresenham line rasterizer: watches the input, result and register
// channels, predicts every result and compares it field by field; depends on blr_pkg

module blr_line_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [blr_pkg::IN_DATA_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y, line_color, pad
  input  logic                           in_tuser,   // op
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [blr_pkg::OUT_DATA_W-1:0] out_tdata,  // pixel_x, pixel_y, pixel_color, pad
  input  logic [blr_pkg::OUT_USER_W-1:0] out_tuser,  // pixel_valid, on_screen
  input  logic                           out_tlast,  // last_pixel
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [blr_pkg::DIM_BITS-1:0]   cfg_data,
  output int                             pending,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB  = blr_pkg::COORD_BITS;
  localparam int CLB = blr_pkg::COLOR_BITS;

  typedef struct packed {
    logic            pixel_valid;
    blr_pkg::coord_t pixel_x;
    blr_pkg::coord_t pixel_y;
    blr_pkg::color_t pixel_color;
    logic            on_screen;
    logic            last_pixel;
  } pixel_res_t;

  pixel_res_t expected_pixels[$];

  blr_pkg::dim_t   scr_w, scr_h;
  logic            ln_busy, ln_steep, ln_minor_neg;
  int              ln_major, ln_major_end, ln_minor, ln_dmajor, ln_dminor, ln_err;
  blr_pkg::color_t ln_color;
  int              mismatches;

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // one item of line walking: start loads and normalizes, a step on a busy line emits a pixel
  function automatic pixel_res_t raster_step(input blr_pkg::op_t op,
                                             input blr_pkg::coord_t sx,
                                             input blr_pkg::coord_t sy,
                                             input blr_pkg::coord_t ex,
                                             input blr_pkg::coord_t ey,
                                             input blr_pkg::color_t c);
    pixel_res_t res;
    int ax, ay, bx, by, t, px, py;
    logic last;
    res = '0;
    if (op == blr_pkg::OP_START) begin
      ax = sx;
      ay = sy;
      bx = ex;
      by = ey;
      ln_steep = iabs(by - ay) > iabs(bx - ax);
      if (ln_steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      // walk with the major coordinate rising
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      ln_major     = ax;
      ln_major_end = bx;
      ln_minor     = ay;
      ln_dmajor    = bx - ax;
      ln_dminor    = iabs(by - ay);
      ln_err       = ln_dmajor / 2;
      ln_minor_neg = !(ay < by);
      ln_color     = c;
      ln_busy      = 1'b1;
    end else if (ln_busy) begin
      px   = ln_steep ? ln_minor : ln_major;
      py   = ln_steep ? ln_major : ln_minor;
      last = ln_major >= ln_major_end;
      res.pixel_valid = 1'b1;
      res.pixel_x     = blr_pkg::coord_t'(px);
      res.pixel_y     = blr_pkg::coord_t'(py);
      res.pixel_color = ln_color;
      res.on_screen   = px >= 0 && px < int'(scr_w) && py >= 0 && py < int'(scr_h);
      res.last_pixel  = last;
      ln_err = ln_err - ln_dminor;
      if (ln_err < 0) begin
        ln_minor = ln_minor + (ln_minor_neg ? -1 : 1);
        ln_err   = ln_err + ln_dmajor;
      end
      if (last) begin
        ln_busy = 1'b0;
      end else begin
        ln_major = ln_major + 1;
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_res_t want;
    if (!rst_n) begin
      expected_pixels.delete();
      scr_w        = blr_pkg::WIDTH_RESET;
      scr_h        = blr_pkg::HEIGHT_RESET;
      ln_busy      = 1'b0;
      ln_steep     = 1'b0;
      ln_minor_neg = 1'b0;
      ln_major     = 0;
      ln_major_end = 0;
      ln_minor     = 0;
      ln_dmajor    = 0;
      ln_dminor    = 0;
      ln_err       = 0;
      ln_color     = '0;
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (blr_pkg::cfg_idx_t'(cfg_index))
          blr_pkg::CFG_SCREEN_WIDTH:  scr_w = cfg_data;
          blr_pkg::CFG_SCREEN_HEIGHT: scr_h = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(raster_step(blr_pkg::op_t'(in_tuser),
                                              blr_pkg::coord_t'(in_tdata[0*CB +: CB]),
                                              blr_pkg::coord_t'(in_tdata[1*CB +: CB]),
                                              blr_pkg::coord_t'(in_tdata[2*CB +: CB]),
                                              blr_pkg::coord_t'(in_tdata[3*CB +: CB]),
                                              blr_pkg::color_t'(in_tdata[4*CB +: CLB])));
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("result transfer with no result expected");
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_valid", want.pixel_valid, out_tuser[0]);
          check_field("pixel_x", want.pixel_x, blr_pkg::coord_t'(out_tdata[0 +: CB]));
          check_field("pixel_y", want.pixel_y, blr_pkg::coord_t'(out_tdata[CB +: CB]));
          check_field("pixel_color", want.pixel_color, out_tdata[2*CB +: CLB]);
          check_field("on_screen", want.on_screen, out_tuser[1]);
          check_field("last_pixel", want.last_pixel, out_tlast);
        end
      end
    end
    pending    <= expected_pixels.size();
    fail_count <= mismatches;
  end

endmodule

@@ dv/tb_top.sv @@
// top of the line rasterizer testbench: clock, reset, stimulus, result backpressure, verdict
// depends on blr_pkg, bresenham_line_raster and blr_line_checker

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [blr_pkg::IN_DATA_W-1:0]  in_tdata;   // start_x, start_y, end_x, end_y, line_color, pad
  logic                           in_tuser;   // op
  logic                           out_tvalid;
  logic                           out_tready;
  logic [blr_pkg::OUT_DATA_W-1:0] out_tdata;  // pixel_x, pixel_y, pixel_color, pad
  logic [blr_pkg::OUT_USER_W-1:0] out_tuser;  // pixel_valid, on_screen
  logic                           out_tlast;  // last_pixel
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_index;
  logic [blr_pkg::DIM_BITS-1:0]   cfg_data;

  int pending;
  int fail_count;
  int cycle_cnt = 0;

  // sender bookkeeping, only touched by the stimulus process
  int burst_left = 0;
  int items_sent = 0;
  int cur_w      = 320;
  int cur_h      = 240;
  // bumped once per random phase to ask the receiver for a long hold-off
  int hold_ticket = 0;

  typedef enum int {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_mode_t;

  always #2 clk = ~clk;

  bresenham_line_raster uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  blr_line_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // saturate to the signed coordinate range
  function automatic blr_pkg::coord_t to_coord(input int v);
    if (v > 16383) return blr_pkg::coord_t'(16383);
    if (v < -16384) return blr_pkg::coord_t'(-16384);
    return blr_pkg::coord_t'(v);
  endfunction

  // one input transfer; bursts of random length separated by random gaps
  task automatic push_item(input blr_pkg::op_t op, input blr_pkg::coord_t sx,
                           input blr_pkg::coord_t sy, input blr_pkg::coord_t ex,
                           input blr_pkg::coord_t ey, input blr_pkg::color_t c);
    int gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(blr_pkg::IN_DATA_W - blr_pkg::IN_FIELD_BITS){1'b0}}, c, ey, ex, sy, sx};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // step items carry random junk in the unused endpoint and color fields
  task automatic send_steps(input int n);
    for (int i = 0; i < n; i++) begin
      push_item(blr_pkg::OP_STEP, blr_pkg::coord_t'($urandom), blr_pkg::coord_t'($urandom),
                blr_pkg::coord_t'($urandom), blr_pkg::coord_t'($urandom),
                blr_pkg::color_t'($urandom));
    end
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // both size registers in back-to-back transfers, only while the block is idle
  task automatic set_screen(input blr_pkg::dim_t w, input blr_pkg::dim_t h);
    cfg_valid <= 1'b1;
    cfg_index <= blr_pkg::CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= blr_pkg::CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // mostly complete lines with random content, plus stray steps and dropped lines
  task automatic run_phase(input int quota);
    int stop_at, kind, len, n, dx, dy, adx, ady, nsteps, bx, by;
    blr_pkg::coord_t sx, sy, ex, ey;
    stop_at = items_sent + quota;
    hold_ticket <= hold_ticket + 1;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // noise: steps that may land on an idle block
        send_steps($urandom_range(1, 3));
      end else if (kind < 14) begin
        // huge line from anywhere, cut short by the next start
        push_item(blr_pkg::OP_START, blr_pkg::coord_t'($urandom), blr_pkg::coord_t'($urandom),
                  blr_pkg::coord_t'($urandom), blr_pkg::coord_t'($urandom),
                  blr_pkg::color_t'($urandom));
        send_steps($urandom_range(0, 4));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          bx = int'(blr_pkg::coord_t'($urandom));
          by = int'(blr_pkg::coord_t'($urandom));
        end else begin
          // near the visible window so the clip flag toggles
          bx = int'($urandom_range(0, cur_w + 16)) - 8;
          by = int'($urandom_range(0, cur_h + 16)) - 8;
        end
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 150) : $urandom_range(0, 16);
        dx  = int'($urandom_range(0, 2 * len)) - len;
        dy  = int'($urandom_range(0, 2 * len)) - len;
        if ($urandom_range(0, 1) == 1) begin
          dx = ($urandom_range(0, 1) == 1) ? len : -len;
        end else begin
          dy = ($urandom_range(0, 1) == 1) ? len : -len;
        end
        sx  = to_coord(bx);
        sy  = to_coord(by);
        ex  = to_coord(bx + dx);
        ey  = to_coord(by + dy);
        adx = int'(ex) - int'(sx);
        ady = int'(ey) - int'(sy);
        if (adx < 0) adx = -adx;
        if (ady < 0) ady = -ady;
        n = ((adx > ady) ? adx : ady) + 1;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          nsteps = $urandom_range(0, n - 1);
        end else if (kind < 27) begin
          nsteps = n + $urandom_range(1, 2);
        end else begin
          nsteps = n;
        end
        push_item(blr_pkg::OP_START, sx, sy, ex, ey, blr_pkg::color_t'($urandom));
        send_steps(nsteps);
      end
    end
  endtask

  // result side: changing ready patterns, plus one long hold-off per random phase
  initial begin
    ready_mode_t mode;
    int mode_left, hold_left, holds_served;
    out_tready   = 1'b0;
    mode         = RDY_ALWAYS;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != holds_served) begin
        holds_served = hold_ticket;
        hold_left    = $urandom_range(80, 150);
      end
      if (hold_left > 0) begin
        // long stall so the internal queue fills and in_tready drops
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_HALF:   out_tready <= 1'($urandom_range(0, 1));
          RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:    out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = blr_pkg::OP_STEP;
    cfg_valid = 1'b0;
    cfg_index = blr_pkg::CFG_SCREEN_WIDTH;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines under the reset size of 320 by 240
    send_steps(1);                                               // step with no line
    // single point line
    push_item(blr_pkg::OP_START, blr_pkg::coord_t'(0), blr_pkg::coord_t'(0),
              blr_pkg::coord_t'(0), blr_pkg::coord_t'(0), 16'hFFFF);
    send_steps(2);                                               // last pixel, then idle
    // widest diagonal
    push_item(blr_pkg::OP_START, blr_pkg::coord_t'(-16384), blr_pkg::coord_t'(16383),
              blr_pkg::coord_t'(16383), blr_pkg::coord_t'(-16384), 16'h0000);
    send_steps(2);
    // steep, across the corner
    push_item(blr_pkg::OP_START, blr_pkg::coord_t'(319), blr_pkg::coord_t'(239),
              blr_pkg::coord_t'(321), blr_pkg::coord_t'(236), 16'hA5A5);
    send_steps(4);
    // reversed horizontal
    push_item(blr_pkg::OP_START, blr_pkg::coord_t'(16383), blr_pkg::coord_t'(-16384),
              blr_pkg::coord_t'(16380), blr_pkg::coord_t'(-16384), 16'h5A5A);
    send_steps(4);
    // starts left of screen
    push_item(blr_pkg::OP_START, blr_pkg::coord_t'(-1), blr_pkg::coord_t'(0),
              blr_pkg::coord_t'(1), blr_pkg::coord_t'(1), 16'h8001);
    send_steps(3);
    wait_idle();

    // random phases at several screen sizes, zero and the extremes among them
    set_screen(blr_pkg::dim_t'(1), blr_pkg::dim_t'(1));
    run_phase(310);
    wait_idle();
    set_screen(blr_pkg::dim_t'(16383), blr_pkg::dim_t'(16383));
    run_phase(310);
    wait_idle();
    set_screen(blr_pkg::dim_t'(0), blr_pkg::dim_t'($urandom_range(1, 16383)));
    run_phase(310);
    wait_idle();
    set_screen(blr_pkg::dim_t'($urandom_range(1, 16383)), blr_pkg::dim_t'(0));
    run_phase(310);
    wait_idle();
    set_screen(blr_pkg::dim_t'(64), blr_pkg::dim_t'(48));
    run_phase(310);
    wait_idle();
    set_screen(blr_pkg::dim_t'(320), blr_pkg::dim_t'(240));
    run_phase(310);
    wait_idle();

    // let the three-stage pipeline settle
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
